// ===== hw/rtl/lcf_pkg.sv =====
// Shared types and constants for the linear convolution FIR.
package lcf_pkg;

   localparam int MAX_TAPS_DEF = 64;
   localparam int SAMPLE_W     = 16;
   localparam int PROD_W       = 32;
   localparam int Y_W          = 40;
   localparam int TAP_COUNT_W  = 7;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic signed [63:0] Y_MAX = 64'sd549755813887;
   localparam logic signed [63:0] Y_MIN = -Y_MAX - 64'sd1;

   localparam logic REG_TAP_COUNT = 1'b0;

   typedef enum logic [1:0] {
      KIND_LOAD   = 2'd0,
      KIND_SAMPLE = 2'd1,
      KIND_FLUSH  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear;
      logic push;
      logic rotate;
      logic load;
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/linear_convolution_fir.sv =====
// Top level of the streaming FIR giving the full linear convolution.
//
// Input words arrive on req_*: tuser carries the kind (load tap, sample,
// flush), tdata the Q1.15 value. Results leave on rsp_*: tdata the Q10.30
// output, tlast set on the final tail word of a flush.
// Taps load one word per cycle while idle, at the load index, which wraps
// at tap_count and returns to zero on any tap_count write via the csr_* port.
// A sample shifts into the delay line, then the first tap_count cells
// rotate once past the multiplier at the head; the result passes the DRAIN
// and EMIT states to the output register, and the next word waits for IDLE.
// A flush gives tap_count - 1 tail words, each through a full rotation,
// then clears the delay line; with one tap it only clears.
// The cell rotation through the single head multiplier sets this pace.
// The output register holds a finished word while the receiver stalls;
// the next input word is accepted meanwhile, and its result waits until
// the register is free.
// Reset clears the delay line, the load index and the output valid flag and
// sets tap_count to one; the taps hold no value until loaded.
module linear_convolution_fir #(
   parameter int MAX_TAPS = lcf_pkg::MAX_TAPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // tdata: value[15:0]
   input  logic [15:0]                       req_tdata,
   // tuser: kind[1:0]
   input  logic [1:0]                        req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: y[39:0]
   output logic [39:0]                       rsp_tdata,
   output logic                              rsp_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lcf_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [lcf_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [lcf_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int NW = $clog2(MAX_TAPS + 1);
   localparam int IW = $clog2(MAX_TAPS);

   lcf_pkg::state_type     state_ff, state_in;
   lcf_pkg::cell_ctrl_type ctrl;
   lcf_pkg::kind_type      kind;

   logic [lcf_pkg::TAP_COUNT_W-1:0] tap_count_ff, tap_count_in;
   logic [IW-1:0]                   idx_ff, idx_in;
   logic [IW-1:0]                   cnt_ff, cnt_in;
   logic [NW-1:0]                   remain_ff, remain_in;
   logic                            flush_ff, flush_in;
   logic [NW-1:0]                   n;
   logic [NW-1:0]                   idx_next;
   logic                            csr_write;

   logic signed [lcf_pkg::SAMPLE_W-1:0] push_val;
   logic signed [lcf_pkg::SAMPLE_W-1:0] hist [MAX_TAPS];
   logic signed [lcf_pkg::SAMPLE_W-1:0] tap  [MAX_TAPS];

   logic                          mac_clear;
   logic                          mac_en;
   logic signed [lcf_pkg::Y_W-1:0] mac_y;

   logic                          out_load;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic [lcf_pkg::Y_W-1:0]       rsp_y_ff, rsp_y_in;

   assign kind = lcf_pkg::kind_type'(req_tuser);

   always_comb begin
      priority if (tap_count_ff == '0) begin
         n = NW'(1);
      end else if (32'(tap_count_ff) > MAX_TAPS) begin
         n = NW'(MAX_TAPS);
      end else begin
         n = NW'(tap_count_ff);
      end
   end

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == lcf_pkg::REG_TAP_COUNT)
                       ? lcf_pkg::CSR_DATA_W'(tap_count_ff) : '0;

   assign idx_next = NW'(idx_ff) + NW'(1);

   always_comb begin
      state_in     = state_ff;
      ctrl         = '0;
      push_val     = '0;
      mac_clear    = 1'b0;
      mac_en       = 1'b0;
      out_load     = 1'b0;
      req_tready   = 1'b0;
      cnt_in       = cnt_ff;
      remain_in    = remain_ff;
      flush_in     = flush_ff;
      idx_in       = idx_ff;
      tap_count_in = tap_count_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_y_in     = rsp_y_ff;

      unique case (state_ff)
         lcf_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (kind)
                  lcf_pkg::KIND_LOAD: begin
                     ctrl.load = 1'b1;
                     idx_in    = (idx_next >= n) ? '0 : idx_next[IW-1:0];
                  end
                  lcf_pkg::KIND_SAMPLE: begin
                     ctrl.push = 1'b1;
                     push_val  = req_tdata;
                     mac_clear = 1'b1;
                     cnt_in    = '0;
                     flush_in  = 1'b0;
                     state_in  = lcf_pkg::ST_ROTATE;
                  end
                  lcf_pkg::KIND_FLUSH: begin
                     if (n == NW'(1)) begin
                        ctrl.clear = 1'b1;
                     end else begin
                        ctrl.push = 1'b1;
                        mac_clear = 1'b1;
                        cnt_in    = '0;
                        remain_in = n - NW'(1);
                        flush_in  = 1'b1;
                        state_in  = lcf_pkg::ST_ROTATE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         lcf_pkg::ST_ROTATE: begin
            ctrl.rotate = 1'b1;
            mac_en      = 1'b1;
            cnt_in      = cnt_ff + IW'(1);
            if (NW'(cnt_ff) == (n - NW'(1))) begin
               state_in = lcf_pkg::ST_DRAIN;
            end
         end
         lcf_pkg::ST_DRAIN: begin
            state_in = lcf_pkg::ST_EMIT;
         end
         lcf_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load    = 1'b1;
               rsp_y_in    = mac_y;
               rsp_last_in = flush_ff && (remain_ff == NW'(1));
               priority if (flush_ff && (remain_ff != NW'(1))) begin
                  ctrl.push = 1'b1;
                  mac_clear = 1'b1;
                  cnt_in    = '0;
                  remain_in = remain_ff - NW'(1);
                  state_in  = lcf_pkg::ST_ROTATE;
               end else if (flush_ff) begin
                  ctrl.clear = 1'b1;
                  state_in   = lcf_pkg::ST_IDLE;
               end else begin
                  state_in = lcf_pkg::ST_IDLE;
               end
            end
         end
      endcase

      if (csr_write && (csr_paddr[2] == lcf_pkg::REG_TAP_COUNT)) begin
         tap_count_in = csr_pwdata[lcf_pkg::TAP_COUNT_W-1:0];
         idx_in       = '0;
      end
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcf_pkg::ST_IDLE;
         tap_count_ff <= lcf_pkg::TAP_COUNT_W'(1);
         idx_ff       <= '0;
         cnt_ff       <= '0;
         remain_ff    <= '0;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_count_ff <= tap_count_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         remain_ff    <= remain_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
   end

   for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
      logic signed [lcf_pkg::SAMPLE_W-1:0] prev_h;
      logic signed [lcf_pkg::SAMPLE_W-1:0] next_h;
      logic signed [lcf_pkg::SAMPLE_W-1:0] next_g;

      if (k == 0) begin : g_first
         assign prev_h = push_val;
      end else begin : g_mid
         assign prev_h = hist[k-1];
      end

      if (k == MAX_TAPS - 1) begin : g_end
         assign next_h = hist[0];
         assign next_g = tap[0];
      end else begin : g_inner
         assign next_h = hist[k+1];
         assign next_g = tap[k+1];
      end

      lcf_cell #(
         .MAX_TAPS (MAX_TAPS),
         .IDX      (k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .n          (n),
         .load_index (idx_ff),
         .load_value (req_tdata),
         .prev_h     (prev_h),
         .next_h     (next_h),
         .next_g     (next_g),
         .head_h     (hist[0]),
         .head_g     (tap[0]),
         .h          (hist[k]),
         .g          (tap[k])
      );
   end

   lcf_mac #(
      .MAX_TAPS (MAX_TAPS)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .clear  (mac_clear),
      .enable (mac_en),
      .h      (hist[0]),
      .g      (tap[0]),
      .y      (mac_y)
   );

   assign rsp_tdata  = rsp_y_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== hw/rtl/lcf_cell.sv =====
// One tap cell: holds a delay-line sample and a kernel tap.
module lcf_cell #(
   parameter int MAX_TAPS = lcf_pkg::MAX_TAPS_DEF,
   parameter int IDX      = 0,
   localparam int NW      = $clog2(MAX_TAPS + 1),
   localparam int IW      = $clog2(MAX_TAPS)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lcf_pkg::cell_ctrl_type              ctrl,
   input  logic [NW-1:0]                       n,
   input  logic [IW-1:0]                       load_index,
   input  logic signed [lcf_pkg::SAMPLE_W-1:0] load_value,
   input  logic signed [lcf_pkg::SAMPLE_W-1:0] prev_h,
   input  logic signed [lcf_pkg::SAMPLE_W-1:0] next_h,
   input  logic signed [lcf_pkg::SAMPLE_W-1:0] next_g,
   input  logic signed [lcf_pkg::SAMPLE_W-1:0] head_h,
   input  logic signed [lcf_pkg::SAMPLE_W-1:0] head_g,
   output logic signed [lcf_pkg::SAMPLE_W-1:0] h,
   output logic signed [lcf_pkg::SAMPLE_W-1:0] g
);

   localparam logic [NW-1:0] POS = NW'(IDX);

   logic signed [lcf_pkg::SAMPLE_W-1:0] h_ff, h_in;
   logic signed [lcf_pkg::SAMPLE_W-1:0] g_ff, g_in;
   logic                                active;
   logic                                wrap;

   assign active = POS < n;
   assign wrap   = POS == (n - NW'(1));

   always_comb begin
      h_in = h_ff;
      g_in = g_ff;
      priority if (ctrl.clear) begin
         h_in = '0;
      end else if (ctrl.push) begin
         h_in = prev_h;
      end else if (ctrl.rotate && active) begin
         h_in = wrap ? head_h : next_h;
         g_in = wrap ? head_g : next_g;
      end else if (ctrl.load && (load_index == IW'(IDX))) begin
         g_in = load_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff <= '0;
      end else begin
         h_ff <= h_in;
      end
   end

   always_ff @(posedge clock) begin
      g_ff <= g_in;
   end

   assign h = h_ff;
   assign g = g_ff;

endmodule

// ===== hw/rtl/lcf_mac.sv =====
// Multiply-accumulate at the head of the chain, with output saturation.
module lcf_mac #(
   parameter int MAX_TAPS = lcf_pkg::MAX_TAPS_DEF,
   localparam int ACC_W   = (lcf_pkg::PROD_W + $clog2(MAX_TAPS) > lcf_pkg::Y_W)
                            ? lcf_pkg::PROD_W + $clog2(MAX_TAPS) : lcf_pkg::Y_W
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                clear,
   input  logic                                enable,
   input  logic signed [lcf_pkg::SAMPLE_W-1:0] h,
   input  logic signed [lcf_pkg::SAMPLE_W-1:0] g,
   output logic signed [lcf_pkg::Y_W-1:0]      y
);

   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(lcf_pkg::Y_MAX);
   localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(lcf_pkg::Y_MIN);

   logic signed [lcf_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic                              prod_vld_ff;
   logic signed [ACC_W-1:0]           acc_ff, acc_in;
   logic signed [ACC_W-1:0]           acc_sat;

   assign prod_in = lcf_pkg::PROD_W'(h) * lcf_pkg::PROD_W'(g);

   always_comb begin
      acc_in = acc_ff;
      priority if (clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_comb begin
      priority if (acc_ff > SAT_HI) begin
         acc_sat = SAT_HI;
      end else if (acc_ff < SAT_LO) begin
         acc_sat = SAT_LO;
      end else begin
         acc_sat = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= enable;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign y = acc_sat[lcf_pkg::Y_W-1:0];

endmodule
